@@ design/cte_pkg.sv @@
// ----------------------------------------------------------------------------
// cte_pkg: shared types and constants of the counting trie engine
// Node pool sizes, field widths, opcodes, result codes, controller states and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cte_pkg;

   localparam int NODE_COUNT  = 1024;
   localparam int ALPHABET    = 26;
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int FREE_W      = NODE_W + 1;
   localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET;
   localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
   localparam int LETTER_W    = 5;
   localparam int COUNT_W     = 16;

   typedef enum logic [1:0] {
      OP_INSERT       = 2'd0,
      OP_COUNT_WORDS  = 2'd1,
      OP_COUNT_PREFIX = 2'd2,
      OP_ERASE        = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_POOL_FULL  = 2'd1,
      ST_ERASE_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LINK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic link;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic item_walks;
      logic item_ends;
      logic go_finish;
      logic item_final;
      logic rsp_free;
   } sts_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_dec(input logic [COUNT_W-1:0] v);
      sat_dec = (v == '0) ? v : v - COUNT_W'(1);
   endfunction

endpackage

@@ design/counting_trie_engine.sv @@
// ----------------------------------------------------------------------------
// counting_trie_engine: lowercase prefix trie with word and prefix counts
// Words arrive one letter per request; insert, exact count, prefix count and
// erase each give one result on the word's final request.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  req     | req_valid, req_stall | opcode, letter, empty_word, last_letter
//  rsp     | rsp_valid, rsp_stall | count, status
//
// A letter request steps through accept with the child-link read, link
// resolution with the count read, then the count update; a non-final query
// letter, or a non-final letter whose link fails, skips the count update. An
// empty-word request, or one after the word has failed, skips link resolution
// and reaches the last step only if it ends the word. The registered reads of
// the node-pool memories set these steps. After reset a clearing pass zeroes
// the pool; req_stall is high during it. A final request waits in its last
// step while a previous result is still held and stalled on the rsp side.
// ----------------------------------------------------------------------------
module counting_trie_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [cte_pkg::LETTER_W-1:0] req_letter,
   input  logic                         req_empty_word,
   input  logic                         req_last_letter,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [cte_pkg::COUNT_W-1:0]  rsp_count,
   output logic [1:0]                   rsp_status
);

   cte_pkg::cmd_type cmd;
   cte_pkg::sts_type sts;

   cte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cte_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_letter      (req_letter),
      .req_empty_word  (req_empty_word),
      .req_last_letter (req_last_letter),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_count       (rsp_count),
      .rsp_status      (rsp_status)
   );

endmodule

@@ design/cte_ram.sv @@
// ----------------------------------------------------------------------------
// cte_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module cte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/cte_ctrl.sv @@
// ----------------------------------------------------------------------------
// cte_ctrl: sequencing state machine of the counting trie engine
// Runs the clearing pass after reset, then steps each request through the
// child-link lookup and the counter update where its kind needs them.
// ----------------------------------------------------------------------------
module cte_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cte_pkg::sts_type sts,
   output cte_pkg::cmd_type cmd
);

   cte_pkg::state_type state_ff;
   cte_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cte_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cte_pkg::S_CLEAR: begin
            if (sts.clear_done) begin
               state_in = cte_pkg::S_IDLE;
            end
         end
         cte_pkg::S_IDLE: begin
            if (req_valid) begin
               if (sts.item_walks) begin
                  state_in = cte_pkg::S_LINK;
               end else if (sts.item_ends) begin
                  state_in = cte_pkg::S_FINISH;
               end
            end
         end
         cte_pkg::S_LINK: begin
            state_in = sts.go_finish ? cte_pkg::S_FINISH : cte_pkg::S_IDLE;
         end
         cte_pkg::S_FINISH: begin
            if (!sts.item_final || sts.rsp_free) begin
               state_in = cte_pkg::S_IDLE;
            end
         end
         default: state_in = cte_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         cte_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         cte_pkg::S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         cte_pkg::S_LINK: begin
            cmd.link = 1'b1;
         end
         cte_pkg::S_FINISH: begin
            // A word's result waits here until the output register is free.
            cmd.finish = !sts.item_final || sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_link_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cte_pkg::S_LINK) |-> $past(cmd.accept))
      else $error("link step without an accepted request");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cte_pkg::S_FINISH && sts.item_final && !sts.rsp_free)
         |=> (state_ff == cte_pkg::S_FINISH))
      else $error("final request left before its result was stored");

endmodule

@@ design/cte_datapath.sv @@
// ----------------------------------------------------------------------------
// cte_datapath: node pool, walk registers and result register
// Holds the child-link table and the two count tables, the walk position,
// the bump allocator and the failure flags of the word in progress.
// ----------------------------------------------------------------------------
module cte_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  cte_pkg::cmd_type                cmd,
   output cte_pkg::sts_type                sts,
   input  logic [1:0]                      req_opcode,
   input  logic [cte_pkg::LETTER_W-1:0]    req_letter,
   input  logic                            req_empty_word,
   input  logic                            req_last_letter,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cte_pkg::COUNT_W-1:0]     rsp_count,
   output logic [1:0]                      rsp_status
);

   // Walk and allocator state.
   logic [cte_pkg::NODE_W-1:0]   walk_pos_ff, walk_pos_in;
   logic [cte_pkg::FREE_W-1:0]   next_free_ff, next_free_in;
   logic                         failed_ff, failed_in;
   cte_pkg::status_type          kind_ff, kind_in;
   logic [cte_pkg::CHILD_AW-1:0] clear_idx_ff;

   // Current request.
   cte_pkg::opcode_type          op_ff;
   logic                         empty_ff;
   logic                         last_ff;
   logic [cte_pkg::CHILD_AW-1:0] child_addr_ff;

   // Result register.
   logic                         rsp_valid_ff;
   logic [cte_pkg::COUNT_W-1:0]  rsp_count_ff;
   cte_pkg::status_type          rsp_status_ff;

   logic [cte_pkg::LETTER_W-1:0] letter_mod;
   logic [cte_pkg::CHILD_AW-1:0] child_addr;
   logic [cte_pkg::NODE_W-1:0]   child_rd;
   logic [cte_pkg::COUNT_W-1:0]  pass_rd, end_rd;
   logic                         miss, pool_full, link_fail, final_q;
   logic [cte_pkg::NODE_W-1:0]   nxt;

   logic                         child_we;
   logic [cte_pkg::CHILD_AW-1:0] child_wa;
   logic [cte_pkg::NODE_W-1:0]   child_wd;
   logic                         pass_we, end_we;
   logic [cte_pkg::NODE_W-1:0]   cnt_wa, cnt_ra;
   logic [cte_pkg::COUNT_W-1:0]  pass_wd, end_wd;
   logic [cte_pkg::COUNT_W-1:0]  result_count;

   assign letter_mod = (req_letter >= cte_pkg::LETTER_W'(cte_pkg::ALPHABET))
                       ? req_letter - cte_pkg::LETTER_W'(cte_pkg::ALPHABET) : req_letter;
   assign child_addr = cte_pkg::CHILD_AW'(walk_pos_ff) * cte_pkg::CHILD_AW'(cte_pkg::ALPHABET)
                       + cte_pkg::CHILD_AW'(letter_mod);

   assign final_q   = empty_ff | last_ff;
   assign miss      = (child_rd == '0);
   assign pool_full = (next_free_ff == cte_pkg::FREE_W'(cte_pkg::NODE_COUNT));
   assign link_fail = miss && ((op_ff != cte_pkg::OP_INSERT) || pool_full);
   assign nxt       = miss ? next_free_ff[cte_pkg::NODE_W-1:0] : child_rd;

   always_comb begin
      sts.clear_done = (clear_idx_ff == cte_pkg::CHILD_AW'(cte_pkg::CHILD_DEPTH - 1));
      sts.item_walks = !req_empty_word && !failed_ff;
      sts.item_ends  = req_empty_word || req_last_letter;
      sts.go_finish  = final_q || (!link_fail &&
                       (op_ff == cte_pkg::OP_INSERT || op_ff == cte_pkg::OP_ERASE));
      sts.item_final = final_q;
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Memory ports.
   always_comb begin
      child_we = 1'b0;
      child_wa = child_addr_ff;
      child_wd = nxt;
      if (cmd.clear_step) begin
         child_we = 1'b1;
         child_wa = clear_idx_ff;
         child_wd = '0;
      end else if (cmd.link && miss && !link_fail) begin
         child_we = 1'b1;
      end
   end

   always_comb begin
      cnt_ra       = cmd.link ? nxt : walk_pos_ff;
      cnt_wa       = walk_pos_ff;
      pass_we      = 1'b0;
      end_we       = 1'b0;
      pass_wd      = pass_rd;
      end_wd       = end_rd;
      result_count = '0;
      if (cmd.clear_step) begin
         pass_we = 1'b1;
         end_we  = 1'b1;
         cnt_wa  = clear_idx_ff[cte_pkg::NODE_W-1:0];
         pass_wd = '0;
         end_wd  = '0;
      end else if (cmd.finish && !failed_ff) begin
         // An insert or erase letter step updates the reached node's pass-through count.
         if (!empty_ff) begin
            case (op_ff)
               cte_pkg::OP_INSERT: begin
                  pass_we = 1'b1;
                  pass_wd = cte_pkg::sat_inc(pass_rd);
               end
               cte_pkg::OP_ERASE: begin
                  pass_we = 1'b1;
                  pass_wd = cte_pkg::sat_dec(pass_rd);
               end
               default: pass_we = 1'b0;
            endcase
         end
         if (final_q) begin
            case (op_ff)
               cte_pkg::OP_INSERT: begin
                  end_we = 1'b1;
                  end_wd = cte_pkg::sat_inc(end_rd);
               end
               cte_pkg::OP_ERASE: begin
                  end_we = 1'b1;
                  end_wd = cte_pkg::sat_dec(end_rd);
               end
               cte_pkg::OP_COUNT_WORDS:  result_count = end_rd;
               cte_pkg::OP_COUNT_PREFIX: result_count = pass_rd;
               default:                  result_count = '0;
            endcase
         end
      end
   end

   // Walk state updates.
   always_comb begin
      walk_pos_in  = walk_pos_ff;
      next_free_in = next_free_ff;
      failed_in    = failed_ff;
      kind_in      = kind_ff;
      if (cmd.link) begin
         if (link_fail) begin
            failed_in = 1'b1;
            case (op_ff)
               cte_pkg::OP_INSERT: kind_in = cte_pkg::ST_POOL_FULL;
               cte_pkg::OP_ERASE:  kind_in = cte_pkg::ST_ERASE_MISS;
               default:            kind_in = cte_pkg::ST_OK;
            endcase
         end else begin
            walk_pos_in = nxt;
            if (miss) begin
               next_free_in = next_free_ff + cte_pkg::FREE_W'(1);
            end
         end
      end else if (cmd.finish && final_q) begin
         walk_pos_in = '0;
         failed_in   = 1'b0;
         kind_in     = cte_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_pos_ff  <= '0;
         next_free_ff <= cte_pkg::FREE_W'(1);
         failed_ff    <= 1'b0;
         kind_ff      <= cte_pkg::ST_OK;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         walk_pos_ff  <= walk_pos_in;
         next_free_ff <= next_free_in;
         failed_ff    <= failed_in;
         kind_ff      <= kind_in;
         if (cmd.clear_step) begin
            clear_idx_ff <= clear_idx_ff + cte_pkg::CHILD_AW'(1);
         end
         if (cmd.finish && final_q) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff         <= cte_pkg::opcode_type'(req_opcode);
         empty_ff      <= req_empty_word;
         last_ff       <= req_last_letter;
         child_addr_ff <= child_addr;
      end
      if (cmd.finish && final_q) begin
         rsp_count_ff  <= result_count;
         rsp_status_ff <= failed_ff ? kind_ff : cte_pkg::ST_OK;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   cte_ram #(
      .WIDTH (cte_pkg::NODE_W),
      .DEPTH (cte_pkg::CHILD_DEPTH)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_we),
      .wr_addr (child_wa),
      .wr_data (child_wd),
      .rd_en   (cmd.accept),
      .rd_addr (child_addr),
      .rd_data (child_rd)
   );

   cte_ram #(
      .WIDTH (cte_pkg::COUNT_W),
      .DEPTH (cte_pkg::NODE_COUNT)
   ) u_pass_ram (
      .clock   (clock),
      .wr_en   (pass_we),
      .wr_addr (cnt_wa),
      .wr_data (pass_wd),
      .rd_en   (cmd.accept | cmd.link),
      .rd_addr (cnt_ra),
      .rd_data (pass_rd)
   );

   cte_ram #(
      .WIDTH (cte_pkg::COUNT_W),
      .DEPTH (cte_pkg::NODE_COUNT)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (end_we),
      .wr_addr (cnt_wa),
      .wr_data (end_wd),
      .rd_en   (cmd.accept | cmd.link),
      .rd_addr (cnt_ra),
      .rd_data (end_rd)
   );

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff != '0) &&
      (next_free_ff <= cte_pkg::FREE_W'(cte_pkg::NODE_COUNT)))
      else $error("allocator pointer out of range");

   a_walk_allocated: assert property (@(posedge clock) disable iff (reset)
      cte_pkg::FREE_W'(walk_pos_ff) < next_free_ff)
      else $error("walk position points at an unallocated node");

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && final_q) |=> rsp_valid_ff)
      else $error("finished word did not load the result register");

endmodule

@@ verif/tb_counting_trie_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counting_trie_engine: self-checking bench for the counting trie engine
// A short table of directed words is followed by random words that reuse a
// small set of letters. Each accepted request updates a local trie model, and
// each final request queues the count and status that must come back on the
// rsp channel.
// ----------------------------------------------------------------------------
module tb_counting_trie_engine;
   import cte_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int DIRECTED_ROWS = 28;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      status_type         status;
   } trie_result_t;

   typedef struct packed {
      opcode_type          op;
      logic [LETTER_W-1:0] letter;
      logic                empty;
      logic                last;
      logic                typed;
      logic [COUNT_W-1:0]  count;
      status_type          status;
   } stim_row_t;

   // The typed columns are filled in only where the answer is obvious;
   // every other final row takes its answer from the trie model.
   localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
      '{OP_COUNT_WORDS,  5'd0,  1'b0, 1'b1, 1'b1, 16'd0, ST_OK},
      '{OP_COUNT_PREFIX, 5'd0,  1'b1, 1'b0, 1'b1, 16'd0, ST_OK},
      '{OP_ERASE,        5'd25, 1'b0, 1'b1, 1'b1, 16'd0, ST_ERASE_MISS},
      '{OP_INSERT,       5'd0,  1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_INSERT,       5'd1,  1'b0, 1'b1, 1'b1, 16'd0, ST_OK},
      '{OP_COUNT_WORDS,  5'd0,  1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_COUNT_WORDS,  5'd1,  1'b0, 1'b1, 1'b0, 16'd0, ST_OK},
      '{OP_COUNT_PREFIX, 5'd0,  1'b0, 1'b1, 1'b0, 16'd0, ST_OK},
      '{OP_INSERT,       5'd31, 1'b0, 1'b1, 1'b1, 16'd0, ST_OK},
      '{OP_COUNT_WORDS,  5'd5,  1'b0, 1'b1, 1'b0, 16'd0, ST_OK},
      '{OP_INSERT,       5'd0,  1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_COUNT_PREFIX, 5'd1,  1'b0, 1'b1, 1'b0, 16'd0, ST_OK},
      '{OP_INSERT,       5'd0,  1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_INSERT,       5'd7,  1'b1, 1'b1, 1'b1, 16'd0, ST_OK},
      '{OP_INSERT,       5'd0,  1'b1, 1'b0, 1'b1, 16'd0, ST_OK},
      '{OP_COUNT_WORDS,  5'd31, 1'b1, 1'b1, 1'b0, 16'd0, ST_OK},
      '{OP_ERASE,        5'd0,  1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_ERASE,        5'd1,  1'b0, 1'b1, 1'b1, 16'd0, ST_OK},
      '{OP_ERASE,        5'd0,  1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_ERASE,        5'd1,  1'b0, 1'b1, 1'b1, 16'd0, ST_OK},
      '{OP_ERASE,        5'd0,  1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_ERASE,        5'd16, 1'b0, 1'b1, 1'b1, 16'd0, ST_ERASE_MISS},
      '{OP_COUNT_WORDS,  5'd24, 1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_INSERT,       5'd2,  1'b0, 1'b1, 1'b1, 16'd0, ST_OK},
      '{OP_ERASE,        5'd23, 1'b0, 1'b0, 1'b0, 16'd0, ST_OK},
      '{OP_COUNT_PREFIX, 5'd0,  1'b0, 1'b1, 1'b1, 16'd0, ST_ERASE_MISS},
      '{OP_COUNT_PREFIX, 5'd0,  1'b0, 1'b1, 1'b0, 16'd0, ST_OK},
      '{OP_COUNT_WORDS,  5'd0,  1'b0, 1'b1, 1'b0, 16'd0, ST_OK}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_opcode;
   logic [LETTER_W-1:0] req_letter;
   logic                req_empty_word;
   logic                req_last_letter;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [COUNT_W-1:0]  rsp_count;
   logic [1:0]          rsp_status;

   // Local copy of the trie.
   logic [NODE_W-1:0]  child_link [CHILD_DEPTH];
   logic [COUNT_W-1:0] end_cnt [NODE_COUNT];
   logic [COUNT_W-1:0] pass_cnt [NODE_COUNT];
   int unsigned        alloc_ptr;
   logic [NODE_W-1:0]  walk_node;
   bit                 walk_failed;
   status_type         walk_fail_kind;

   trie_result_t pending_results [$];
   trie_result_t oldest_result;
   int           mismatches = 0;
   int           requests_sent;
   int           cycle_count = 0;
   int           send_idle_pct;
   int           recv_stall_pct;

   counting_trie_engine i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_letter      (req_letter),
      .req_empty_word  (req_empty_word),
      .req_last_letter (req_last_letter),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_count       (rsp_count),
      .rsp_status      (rsp_status)
   );

   always #6 clock = ~clock;

   // Walks one request through the local trie and yields the word's result
   // when the request ends the word.
   task automatic trie_step(input opcode_type op, input logic [LETTER_W-1:0] letter,
                            input bit empty, input bit last,
                            output bit produces, output trie_result_t res);
      int unsigned       slot;
      logic [NODE_W-1:0] child;
      produces = 1'b0;
      res      = '0;
      if (!empty && !walk_failed) begin
         slot  = walk_node * ALPHABET + (letter % ALPHABET);
         child = child_link[slot];
         if (child == '0 && op != OP_INSERT) begin
            // A query miss fails without a status; an erase miss is flagged.
            walk_failed    = 1'b1;
            walk_fail_kind = (op == OP_ERASE) ? ST_ERASE_MISS : ST_OK;
         end else if (child == '0 && alloc_ptr >= NODE_COUNT) begin
            walk_failed    = 1'b1;
            walk_fail_kind = ST_POOL_FULL;
         end else begin
            if (child == '0) begin
               child            = NODE_W'(alloc_ptr);
               child_link[slot] = child;
               alloc_ptr++;
            end
            if (op == OP_INSERT && pass_cnt[child] != '1)
               pass_cnt[child] = pass_cnt[child] + 1'b1;
            else if (op == OP_ERASE && pass_cnt[child] != '0)
               pass_cnt[child] = pass_cnt[child] - 1'b1;
            walk_node = child;
         end
      end
      if (empty || last) begin
         produces = 1'b1;
         if (walk_failed) begin
            res.status = walk_fail_kind;
         end else begin
            case (op)
               OP_INSERT: begin
                  if (end_cnt[walk_node] != '1)
                     end_cnt[walk_node] = end_cnt[walk_node] + 1'b1;
               end
               OP_ERASE: begin
                  if (end_cnt[walk_node] != '0)
                     end_cnt[walk_node] = end_cnt[walk_node] - 1'b1;
               end
               OP_COUNT_WORDS:  res.count = end_cnt[walk_node];
               default:         res.count = pass_cnt[walk_node];
            endcase
         end
         walk_node      = '0;
         walk_failed    = 1'b0;
         walk_fail_kind = ST_OK;
      end
   endtask

   task automatic send_request(input opcode_type op, input logic [LETTER_W-1:0] letter,
                               input bit empty, input bit last, input bit typed,
                               input trie_result_t typed_res);
      bit           produces;
      trie_result_t res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_letter      <= letter;
      req_empty_word  <= empty;
      req_last_letter <= last;
      do @(posedge clock); while (req_stall);
      trie_step(op, letter, empty, last, produces, res);
      if (produces)
         pending_results.push_back(typed ? typed_res : res);
      requests_sent++;
   endtask

   // Most letters come from a small set so that later words share paths.
   function automatic logic [LETTER_W-1:0] pick_letter();
      int r;
      r = $urandom_range(99);
      if (r < 65)
         return LETTER_W'($urandom_range(3));
      else if (r < 90)
         return LETTER_W'($urandom_range(ALPHABET - 1));
      return LETTER_W'($urandom_range(31));
   endfunction

   task automatic send_random_word();
      opcode_type word_op;
      opcode_type item_op;
      int         len;
      int         r;
      bit         empty;
      bit         last;
      r       = $urandom_range(99);
      word_op = (r < 40) ? OP_INSERT : (r < 60) ? OP_COUNT_WORDS :
                (r < 80) ? OP_COUNT_PREFIX : OP_ERASE;
      len     = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
         item_op = ($urandom_range(99) < 8) ? opcode_type'($urandom_range(3)) : word_op;
         empty   = ($urandom_range(99) < 4);
         last    = empty ? 1'($urandom_range(1)) : (i == len - 1);
         send_request(item_op, pick_letter(), empty, last, 1'b0, '0);
         if (empty)
            break;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no request waiting: count %0d status %0d",
                     $time, rsp_count, rsp_status);
            mismatches++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_count !== oldest_result.count) begin
               $display("%0t: count mismatch: expected %0d actual %0d",
                        $time, oldest_result.count, rsp_count);
               mismatches++;
            end
            if (rsp_status !== oldest_result.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, oldest_result.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_INSERT;
      req_letter      = '0;
      req_empty_word  = 1'b0;
      req_last_letter = 1'b0;
      requests_sent   = 0;
      send_idle_pct   = 9;
      recv_stall_pct  = 51;
      foreach (child_link[i])
         child_link[i] = '0;
      foreach (end_cnt[i]) begin
         end_cnt[i]  = '0;
         pass_cnt[i] = '0;
      end
      alloc_ptr      = 1;
      walk_node      = '0;
      walk_failed    = 1'b0;
      walk_fail_kind = ST_OK;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first request waits out the clearing pass through req_stall.
      foreach (DIRECTED[i])
         send_request(DIRECTED[i].op, DIRECTED[i].letter, DIRECTED[i].empty,
                      DIRECTED[i].last, DIRECTED[i].typed,
                      trie_result_t'{DIRECTED[i].count, DIRECTED[i].status});

      while (requests_sent < 200)
         send_random_word();
      send_idle_pct  = 51;
      recv_stall_pct = 9;
      while (requests_sent < 375)
         send_random_word();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (requests_sent < 550)
         send_random_word();

      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
design/cte_pkg.sv
design/cte_ram.sv
design/cte_ctrl.sv
design/cte_datapath.sv
design/counting_trie_engine.sv
verif/tb_counting_trie_engine.sv
